// File: design/hrbd_pkg.sv
// Shared types and constants for the HTTP response body deframer.
package hrbd_pkg;

   localparam int CountWidth = 32;
   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   localparam logic [1:0] KIND_BODY = 2'd0;
   localparam logic [1:0] KIND_SIZE = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   localparam logic [1:0] FRAME_NONE   = 2'd0;
   localparam logic [1:0] FRAME_LENGTH = 2'd1;
   localparam logic [1:0] FRAME_CHUNK  = 2'd2;

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_COLON = 8'h3a;

   localparam int LenCl = 14;
   localparam int LenTe = 17;
   localparam int LenCh = 8;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  body_byte;
      logic [31:0] chunk_size;
      logic [1:0]  framing;
      logic        last;
   } rsp_type;

   function automatic logic [7:0] txt_length(input logic [4:0] i);
      case (i)
         5'd0: txt_length = "C";  5'd1: txt_length = "o";  5'd2: txt_length = "n";
         5'd3: txt_length = "t";  5'd4: txt_length = "e";  5'd5: txt_length = "n";
         5'd6: txt_length = "t";  5'd7: txt_length = "-";  5'd8: txt_length = "L";
         5'd9: txt_length = "e";  5'd10: txt_length = "n"; 5'd11: txt_length = "g";
         5'd12: txt_length = "t"; 5'd13: txt_length = "h";
         default: txt_length = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] txt_encoding(input logic [4:0] i);
      case (i)
         5'd0: txt_encoding = "T";  5'd1: txt_encoding = "r";  5'd2: txt_encoding = "a";
         5'd3: txt_encoding = "n";  5'd4: txt_encoding = "s";  5'd5: txt_encoding = "f";
         5'd6: txt_encoding = "e";  5'd7: txt_encoding = "r";  5'd8: txt_encoding = "-";
         5'd9: txt_encoding = "E";  5'd10: txt_encoding = "n"; 5'd11: txt_encoding = "c";
         5'd12: txt_encoding = "o"; 5'd13: txt_encoding = "d"; 5'd14: txt_encoding = "i";
         5'd15: txt_encoding = "n"; 5'd16: txt_encoding = "g";
         default: txt_encoding = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] txt_chunked(input logic [3:0] i);
      case (i)
         4'd0: txt_chunked = " "; 4'd1: txt_chunked = "c"; 4'd2: txt_chunked = "h";
         4'd3: txt_chunked = "u"; 4'd4: txt_chunked = "n"; 4'd5: txt_chunked = "k";
         4'd6: txt_chunked = "e"; 4'd7: txt_chunked = "d";
         default: txt_chunked = 8'h00;
      endcase
   endfunction

endpackage

// File: design/hrbd_if.sv
// Valid/ready channel interfaces for requests and responses.
interface hrbd_req_if (input logic clock);
   logic                  valid;
   logic                  ready;
   hrbd_pkg::req_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface hrbd_rsp_if (input logic clock);
   logic                  valid;
   logic                  ready;
   hrbd_pkg::rsp_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: design/hrbd_front.sv
// Front end: header line parser, framing classifier and body deframer, one byte per cycle unless its output is stalled.
module hrbd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  hrbd_pkg::req_type    in_data,
   output logic                 in_ready,
   output logic                 out_valid,
   output hrbd_pkg::rsp_type    out_data,
   input  logic                 out_ready
);

   typedef enum logic [7:0] {
      PH_STATUS = 8'b00000001,
      PH_HEADER = 8'b00000010,
      PH_LENGTH = 8'b00000100,
      PH_SIZE   = 8'b00001000,
      PH_DATA   = 8'b00010000,
      PH_TRAIL  = 8'b00100000,
      PH_FINAL  = 8'b01000000,
      PH_DONE   = 8'b10000000
   } phase_type;

   typedef enum logic [2:0] {
      DEC_LEAD  = 3'b001,
      DEC_DIGIT = 3'b010,
      DEC_STOP  = 3'b100
   } dec_type;

   localparam int CW = hrbd_pkg::CountWidth;

   phase_type       phase_ff, phase_in;
   logic            pcr_ff, pcr_in, empty_ff, empty_in, colon_ff, colon_in;
   logic [4:0]      npos_ff, npos_in;
   logic            lmatch_ff, lmatch_in, ematch_ff, ematch_in, cmatch_ff, cmatch_in;
   logic [3:0]      vpos_ff, vpos_in;
   logic [CW-1:0]   dec_ff, dec_in, blen_ff, blen_in, rem_ff, rem_in, hex_ff, hex_in;
   dec_type         dst_ff, dst_in;
   logic            chunk_ff, chunk_in;
   logic            ov_ff, ov_in;
   hrbd_pkg::rsp_type od_ff, od_in;

   logic            accept;
   logic [7:0]      c;
   logic            crlf;
   logic [CW-1:0]   rem_dec;
   logic [CW+3:0]   dec_mul, hex_mul;
   logic [3:0]      hval;
   logic            hok;

   assign in_ready  = !ov_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = ov_ff;
   assign out_data  = od_ff;
   assign c         = in_data.stream_byte;

   always_comb begin
      hok  = 1'b1;
      hval = 4'd0;
      if (c >= "0" && c <= "9") begin
         hval = 4'(c - "0");
      end else if (c >= "A" && c <= "F") begin
         hval = 4'(c - "A" + 8'd10);
      end else if (c >= "a" && c <= "f") begin
         hval = 4'(c - "a" + 8'd10);
      end else begin
         hok = 1'b0;
      end
   end

   always_comb begin
      logic [7:0]    fc;
      logic          feed;
      logic [1:0]    fr;
      logic [CW-1:0] dsrc;
      phase_type     ph;
      logic          pcr, st;

      phase_in = phase_ff; pcr_in = pcr_ff; empty_in = empty_ff; colon_in = colon_ff;
      npos_in = npos_ff; lmatch_in = lmatch_ff; ematch_in = ematch_ff;
      vpos_in = vpos_ff; cmatch_in = cmatch_ff; dec_in = dec_ff; dst_in = dst_ff;
      blen_in = blen_ff; chunk_in = chunk_ff; rem_in = rem_ff; hex_in = hex_ff;
      ov_in = ov_ff && !out_ready;
      od_in = od_ff;
      feed = 1'b0; fc = c; dsrc = dec_ff;
      dec_mul = '0; hex_mul = '0; rem_dec = '0;
      ph = phase_ff; pcr = pcr_ff; st = 1'b0;

      if (accept && in_data.restart) begin
         ph = PH_STATUS; pcr = 1'b0; st = 1'b1;
         empty_in = 1'b1; colon_in = 1'b0; npos_in = '0; lmatch_in = 1'b1;
         ematch_in = 1'b1; vpos_in = '0; cmatch_in = 1'b1; dec_in = '0; dst_in = DEC_LEAD;
         blen_in = '0; chunk_in = 1'b0; rem_in = '0; hex_in = '0;
      end
      crlf = (c == hrbd_pkg::CHAR_LF) && pcr;
      rem_dec = (st ? '0 : rem_ff) - 1'b1;
      fr = ((st ? '0 : blen_ff) != '0) ? hrbd_pkg::FRAME_LENGTH :
           ((st ? 1'b0 : chunk_ff) ? hrbd_pkg::FRAME_CHUNK : hrbd_pkg::FRAME_NONE);
      od_in = ov_in ? od_ff : od_ff;

      if (accept) begin
         phase_in = ph; pcr_in = pcr;
         od_in = '{kind: hrbd_pkg::KIND_BODY, body_byte: 8'd0, chunk_size: 32'd0,
                   framing: fr, last: 1'b0};
         case (ph)
            PH_STATUS: begin
               pcr_in = (c == hrbd_pkg::CHAR_CR);
               if (crlf) begin
                  pcr_in = 1'b0; phase_in = PH_HEADER;
                  empty_in = 1'b1; colon_in = 1'b0; npos_in = '0; lmatch_in = 1'b1;
                  ematch_in = 1'b1; vpos_in = '0; cmatch_in = 1'b1; dec_in = '0;
                  dst_in = DEC_LEAD;
               end
            end
            PH_HEADER: begin
               if (!crlf) begin
                  pcr_in = (c == hrbd_pkg::CHAR_CR);
                  if (pcr && c == hrbd_pkg::CHAR_CR) begin
                     feed = 1'b1; fc = hrbd_pkg::CHAR_CR;
                  end else if (pcr) begin
                     // feed the held CR, then this byte
                     feed = 1'b1; fc = hrbd_pkg::CHAR_CR;
                  end else if (c != hrbd_pkg::CHAR_CR) begin
                     feed = 1'b1; fc = c;
                  end
               end else begin
                  pcr_in = 1'b0;
                  if (!empty_ff) begin
                     if (lmatch_ff && npos_ff == 5'(hrbd_pkg::LenCl)) begin
                        blen_in = dec_ff;
                     end else if (ematch_ff && npos_ff == 5'(hrbd_pkg::LenTe) &&
                                  cmatch_ff && vpos_ff == 4'(hrbd_pkg::LenCh)) begin
                        chunk_in = 1'b1;
                     end
                     empty_in = 1'b1; colon_in = 1'b0; npos_in = '0; lmatch_in = 1'b1;
                     ematch_in = 1'b1; vpos_in = '0; cmatch_in = 1'b1; dec_in = '0;
                     dst_in = DEC_LEAD;
                  end else if (blen_ff != '0) begin
                     rem_in = blen_ff; phase_in = PH_LENGTH;
                  end else if (chunk_ff) begin
                     hex_in = '0; phase_in = PH_SIZE;
                  end else begin
                     phase_in = PH_DONE; ov_in = 1'b1;
                     od_in.kind = hrbd_pkg::KIND_END; od_in.last = 1'b1;
                  end
               end
            end
            PH_LENGTH: begin
               rem_in = rem_dec; ov_in = 1'b1; od_in.body_byte = c;
               if (rem_dec == '0) begin
                  phase_in = PH_DONE; od_in.last = 1'b1;
               end
            end
            PH_SIZE: begin
               pcr_in = (c == hrbd_pkg::CHAR_CR);
               if (crlf) begin
                  pcr_in = 1'b0; hex_in = '0; ov_in = 1'b1;
                  od_in.kind = hrbd_pkg::KIND_SIZE; od_in.chunk_size = hex_ff[31:0];
                  if (hex_ff == '0) begin
                     rem_in = CW'(2); phase_in = PH_FINAL;
                  end else begin
                     rem_in = hex_ff; phase_in = PH_DATA;
                  end
               end else if (hok) begin
                  hex_mul = {hex_ff, 4'd0} + (CW+4)'(hval);
                  hex_in = (hex_ff[CW-1:CW-4] != '0 || hex_mul[CW+3:CW] != '0) ?
                           hrbd_pkg::CountMax : hex_mul[CW-1:0];
               end
            end
            PH_DATA: begin
               rem_in = rem_dec; ov_in = 1'b1; od_in.body_byte = c;
               if (rem_dec == '0) begin
                  rem_in = CW'(2); phase_in = PH_TRAIL;
               end
            end
            PH_TRAIL: begin
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  pcr_in = 1'b0; hex_in = '0; phase_in = PH_SIZE;
               end
            end
            PH_FINAL: begin
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  phase_in = PH_DONE; ov_in = 1'b1;
                  od_in.kind = hrbd_pkg::KIND_END; od_in.last = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (feed) begin
         // a pending CR followed by an ordinary byte feeds both bytes
         logic [7:0] b;
         int         k, n;
         logic       clr, lm, em, cm;
         logic [4:0] np;
         logic [3:0] vp;
         dec_type    ds;
         n = (pcr && c != hrbd_pkg::CHAR_CR) ? 2 : 1;
         clr = colon_in; lm = lmatch_in; em = ematch_in; cm = cmatch_in;
         np = npos_in; vp = vpos_in; ds = dst_in; dsrc = dec_in;
         for (k = 0; k < 2; k++) begin
            if (k < n) begin
               b = (k == 0) ? fc : c;
               if (!clr) begin
                  if (b == hrbd_pkg::CHAR_COLON) begin
                     clr = 1'b1;
                  end else begin
                     if (np >= 5'(hrbd_pkg::LenCl) || b != hrbd_pkg::txt_length(np)) lm = 1'b0;
                     if (np >= 5'(hrbd_pkg::LenTe) || b != hrbd_pkg::txt_encoding(np)) em = 1'b0;
                     if (np < 5'd31) np = np + 5'd1;
                  end
               end else begin
                  if (vp >= 4'(hrbd_pkg::LenCh) || b != hrbd_pkg::txt_chunked(vp)) cm = 1'b0;
                  if (vp < 4'd15) vp = vp + 4'd1;
                  if (ds == DEC_LEAD && (b == " " || (b >= 8'd9 && b <= 8'd13))) begin
                  end else if (ds == DEC_LEAD && b == "+") begin
                     ds = DEC_DIGIT;
                  end else if ((ds == DEC_LEAD || ds == DEC_DIGIT) && b >= "0" && b <= "9") begin
                     ds = DEC_DIGIT;
                     dec_mul = {dsrc, 3'd0} + {1'b0, dsrc, 1'b0} + (CW+4)'(b - "0");
                     dsrc = (dec_mul[CW+3:CW] != '0) ? hrbd_pkg::CountMax : dec_mul[CW-1:0];
                  end else if (ds == DEC_LEAD || ds == DEC_DIGIT) begin
                     ds = DEC_STOP;
                  end
               end
            end
         end
         empty_in = 1'b0; colon_in = clr; lmatch_in = lm; ematch_in = em; cmatch_in = cm;
         npos_in = np; vpos_in = vp; dst_in = ds; dec_in = dsrc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STATUS; pcr_ff <= 1'b0; empty_ff <= 1'b1; colon_ff <= 1'b0;
         npos_ff <= '0; lmatch_ff <= 1'b1; ematch_ff <= 1'b1; vpos_ff <= '0;
         cmatch_ff <= 1'b1; dec_ff <= '0; dst_ff <= DEC_LEAD; blen_ff <= '0; chunk_ff <= 1'b0;
         rem_ff <= '0; hex_ff <= '0; ov_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; pcr_ff <= pcr_in; empty_ff <= empty_in; colon_ff <= colon_in;
         npos_ff <= npos_in; lmatch_ff <= lmatch_in; ematch_ff <= ematch_in;
         vpos_ff <= vpos_in; cmatch_ff <= cmatch_in; dec_ff <= dec_in; dst_ff <= dst_in;
         blen_ff <= blen_in; chunk_ff <= chunk_in; rem_ff <= rem_in; hex_ff <= hex_in;
         ov_ff <= ov_in;
      end
      od_ff <= od_in;
   end

endmodule

// File: design/hrbd_queue.sv
// Two-entry result queue between the parser and the output port.
module hrbd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  hrbd_pkg::rsp_type    in_data,
   output logic                 in_ready,
   output logic                 out_valid,
   output hrbd_pkg::rsp_type    out_data,
   input  logic                 out_ready
);

   hrbd_pkg::rsp_type mem_ff [2];
   logic              wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end

endmodule

// File: design/http_response_body_deframer_unit.sv
// Top level of the HTTP response body deframer.
// Usage: the req channel carries one raw response byte per transfer, with
// restart set on the first byte of each new response (parser state clears
// before that byte is used). The rsp channel carries at most one result per
// input byte: body bytes, decoded chunk sizes and an end-of-body marker, each
// tagged with the current framing and a last flag.
// Throughput is one byte per cycle unless rsp back-pressure stalls the parser.
// An accepted byte's result passes through the parser output register and
// then through the two-entry result queue before it reaches rsp.
// When the receiver stalls, the queue fills and then the parser holds its
// output, after which req_ready drops; no result is lost.
// Reset (synchronous, active high) returns the parser to the status line and
// empties the queue.
module http_response_body_deframer_unit (
   input logic        clock,
   input logic        reset,
   hrbd_req_if.sink   req,
   hrbd_rsp_if.source rsp
);

   logic              mid_valid, mid_ready;
   hrbd_pkg::rsp_type mid_data;

   hrbd_front u_front (
      .clock, .reset,
      .in_valid (req.valid), .in_data (req.payload), .in_ready (req.ready),
      .out_valid (mid_valid), .out_data (mid_data), .out_ready (mid_ready)
   );

   hrbd_queue u_queue (
      .clock, .reset,
      .in_valid (mid_valid), .in_data (mid_data), .in_ready (mid_ready),
      .out_valid (rsp.valid), .out_data (rsp.payload), .out_ready (rsp.ready)
   );

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.last |-> rsp.payload.kind != hrbd_pkg::KIND_SIZE)
      else $error("last on chunk size");
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.kind == hrbd_pkg::KIND_END |-> rsp.payload.last)
      else $error("end without last");
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.payload.kind == hrbd_pkg::KIND_BODY ||
      rsp.payload.kind == hrbd_pkg::KIND_SIZE || rsp.payload.kind == hrbd_pkg::KIND_END)
      else $error("bad kind");

endmodule

// File: bench/tb_http_response_body_deframer_unit.sv
// Testbench for the HTTP response body deframer: directed responses, random streams, checked per transfer.
module tb_http_response_body_deframer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      P_STATUS, P_HEADER, P_LENGTH, P_SIZE, P_DATA, P_TRAIL, P_FINAL, P_DONE
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #1 clock = ~clock;

   hrbd_req_if req (clock);
   hrbd_rsp_if rsp (clock);

   http_response_body_deframer_unit u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   // parser model state
   phase_type   ph;
   bit          prev_cr, ln_empty, colon;
   int unsigned name_pos, val_pos;
   bit          cl_match, te_match, ch_match;
   logic [31:0] dec_acc, body_len, remaining, hex_acc;
   int unsigned dec_st;
   bit          chunked;

   hrbd_pkg::rsp_type expected_rsps[$];
   int          errors = 0;
   int          n_sent = 0;
   bit          send_idle = 1'b1;
   bit          recv_idle = 1'b1;
   bit          hold_rsp = 1'b0;

   function automatic logic [7:0] len_txt(int unsigned i);
      string s = "Content-Length";
      return (i < 14) ? s[i] : 8'h00;
   endfunction
   function automatic logic [7:0] enc_txt(int unsigned i);
      string s = "Transfer-Encoding";
      return (i < 17) ? s[i] : 8'h00;
   endfunction
   function automatic logic [7:0] chk_txt(int unsigned i);
      string s = " chunked";
      return (i < 8) ? s[i] : 8'h00;
   endfunction

   function automatic logic [31:0] sat_mac(logic [31:0] acc, int unsigned base,
                                           int unsigned dig);
      logic [63:0] r;
      r = acc * 64'(base) + 64'(dig);
      return (r > 64'hFFFF_FFFF) ? hrbd_pkg::CountMax : r[31:0];
   endfunction

   function automatic void clear_line();
      ln_empty = 1; colon = 0; name_pos = 0; cl_match = 1; te_match = 1;
      val_pos = 0; ch_match = 1; dec_acc = 0; dec_st = 0;
   endfunction

   function automatic void parser_reset();
      ph = P_STATUS; prev_cr = 0; clear_line();
      body_len = 0; chunked = 0; remaining = 0; hex_acc = 0;
   endfunction

   function automatic void feed_decimal(logic [7:0] c);
      bit dig;
      dig = (c >= "0" && c <= "9");
      if (dec_st == 0) begin
         if (c == " " || (c >= 9 && c <= 13)) return;
         if (c == "+") begin dec_st = 1; return; end
         if (dig) begin
            dec_st = 1; dec_acc = sat_mac(dec_acc, 10, c - "0"); return;
         end
         dec_st = 3;
      end else if (dec_st == 1) begin
         if (dig) dec_acc = sat_mac(dec_acc, 10, c - "0");
         else dec_st = 3;
      end
   endfunction

   function automatic void feed_line(logic [7:0] c);
      ln_empty = 0;
      if (!colon) begin
         if (c == hrbd_pkg::CHAR_COLON) begin colon = 1; return; end
         if (name_pos >= 14 || c != len_txt(name_pos)) cl_match = 0;
         if (name_pos >= 17 || c != enc_txt(name_pos)) te_match = 0;
         if (name_pos < 31) name_pos++;
      end else begin
         if (val_pos >= 8 || c != chk_txt(val_pos)) ch_match = 0;
         if (val_pos < 15) val_pos++;
         feed_decimal(c);
      end
   endfunction

   function automatic void push_result(logic [1:0] k, logic [7:0] b, logic [31:0] sz,
                                       bit lst);
      hrbd_pkg::rsp_type r;
      r.kind = k; r.body_byte = b; r.chunk_size = sz; r.last = lst;
      r.framing = (body_len != 0) ? hrbd_pkg::FRAME_LENGTH :
                  (chunked ? hrbd_pkg::FRAME_CHUNK : hrbd_pkg::FRAME_NONE);
      expected_rsps.push_back(r);
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return 16;
   endfunction

   function automatic void parse_byte(logic [7:0] c, bit rst);
      bit crlf;
      int h;
      logic [31:0] sz;
      if (rst) parser_reset();
      crlf = (c == hrbd_pkg::CHAR_LF) && prev_cr;
      case (ph)
         P_STATUS: begin
            prev_cr = (c == hrbd_pkg::CHAR_CR);
            if (crlf) begin prev_cr = 0; clear_line(); ph = P_HEADER; end
         end
         P_HEADER: begin
            if (!crlf) begin
               if (prev_cr) feed_line(hrbd_pkg::CHAR_CR);
               prev_cr = (c == hrbd_pkg::CHAR_CR);
               if (!prev_cr) feed_line(c);
            end else begin
               prev_cr = 0;
               if (!ln_empty) begin
                  if (cl_match && name_pos == 14) body_len = dec_acc;
                  else if (te_match && name_pos == 17 && ch_match && val_pos == 8)
                     chunked = 1;
                  clear_line();
               end else if (body_len != 0) begin
                  remaining = body_len; ph = P_LENGTH;
               end else if (chunked) begin
                  hex_acc = 0; ph = P_SIZE;
               end else begin
                  ph = P_DONE; push_result(hrbd_pkg::KIND_END, 0, 0, 1);
               end
            end
         end
         P_LENGTH: begin
            remaining--;
            if (remaining == 0) begin
               ph = P_DONE; push_result(hrbd_pkg::KIND_BODY, c, 0, 1);
            end
            else push_result(hrbd_pkg::KIND_BODY, c, 0, 0);
         end
         P_SIZE: begin
            prev_cr = (c == hrbd_pkg::CHAR_CR);
            if (crlf) begin
               sz = hex_acc; prev_cr = 0; hex_acc = 0;
               if (sz == 0) begin remaining = 2; ph = P_FINAL; end
               else begin remaining = sz; ph = P_DATA; end
               push_result(hrbd_pkg::KIND_SIZE, 0, sz, 0);
            end else begin
               h = hex_digit(c);
               if (h < 16) hex_acc = sat_mac(hex_acc, 16, h);
            end
         end
         P_DATA: begin
            remaining--;
            if (remaining == 0) begin remaining = 2; ph = P_TRAIL; end
            push_result(hrbd_pkg::KIND_BODY, c, 0, 0);
         end
         P_TRAIL: begin
            remaining--;
            if (remaining == 0) begin prev_cr = 0; hex_acc = 0; ph = P_SIZE; end
         end
         P_FINAL: begin
            remaining--;
            if (remaining == 0) begin
               ph = P_DONE; push_result(hrbd_pkg::KIND_END, 0, 0, 1);
            end
         end
         default: ;
      endcase
   endfunction

   // drive one byte; valid stays high across back-to-back transfers
   task automatic send_byte(logic [7:0] c, bit rst);
      if (send_idle && $urandom_range(0, 9) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= '{stream_byte: c, restart: rst};
      do @(posedge clock); while (!req.ready);
      parse_byte(c, rst);
      n_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(string s, bit rst);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], rst && i == 0);
   endtask

   task automatic drain();
      int n;
      n = 0;
      req.valid <= 1'b0;
      while (expected_rsps.size() != 0 && n < 20000) begin @(negedge clock); n++; end
      repeat (6) @(negedge clock);
   endtask

   // receiver
   initial begin
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!hold_rsp && recv_idle && $urandom_range(0, 9) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp.ready <= !hold_rsp;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      hrbd_pkg::rsp_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp.payload);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp.payload.kind !== e.kind || rsp.payload.body_byte !== e.body_byte ||
                rsp.payload.chunk_size !== e.chunk_size ||
                rsp.payload.framing !== e.framing || rsp.payload.last !== e.last) begin
               errors++;
               $display("%0t: mismatch, expected %p, actual %p", $time, e, rsp.payload);
            end
         end
      end
   end

   function automatic string rand_hdr_line();
      case ($urandom_range(0, 7))
         0: return $sformatf("Content-Length: %0d\r\n", $urandom_range(0, 12));
         1: return "Transfer-Encoding: chunked\r\n";
         2: return "Transfer-Encoding:chunked\r\n";
         3: return "content-length: 5\r\n";
         4: return "X-A:\rb\r\n";
         5: return ":x\r\n";
         6: return "Content-Length\r\n";
         default: return "Host: h\r\n";
      endcase
   endfunction

   task automatic send_noise(int n);
      for (int i = 0; i < n; i++) send_byte($urandom_range(0, 255), 1'b0);
   endtask

   task automatic send_chunked(int nchunks);
      for (int k = 0; k < nchunks; k++) begin
         int sz;
         sz = $urandom_range(1, 12);
         if ($urandom_range(0, 1)) send_text($sformatf("%0x\r\n", sz), 0);
         else send_text($sformatf("%0X;z\r\n", sz), 0);
         send_noise(sz);
         send_noise(2);
      end
      send_text("0\r\n", 0);
      send_noise(2);
   endtask

   task automatic test_directed();
      send_text("HTTP/1.1 200 OK\r\n\r\n", 1);
      send_text("ignored", 0);
      send_text("S\r\nContent-Length: +3\r\n\r\n", 1);
      send_byte(8'h00, 0); send_byte(8'hFF, 0); send_byte(8'h80, 0);
      send_text("S\r\nContent-Length: 99999999999\r\n\r\nab", 1);
      send_text("S\r\nTransfer-Encoding: chunked\r\n\r\nfFfFfFfFfF\r\n", 1);
      send_text("S\r\nTransfer-Encoding: chunked\r\nContent-Length: -4\r\n\r\n", 1);
      send_text("2g\r\nxy??0\r\n\r\n", 0);
   endtask

   task automatic test_random_responses();
      int nh;
      string s;
      s = "HTTP/1.1 200\r\n";
      nh = $urandom_range(0, 4);
      for (int i = 0; i < nh; i++) s = {s, rand_hdr_line()};
      s = {s, "\r\n"};
      send_text(s, 1);
      if (ph == P_LENGTH) send_noise(int'(body_len));
      else if (ph == P_SIZE) send_chunked($urandom_range(0, 3));
      if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 20));
   endtask

   task automatic test_backpressure();
      send_text("S\r\nContent-Length: 40\r\n\r\n", 1);
      fork
         begin hold_rsp = 1; repeat (60) @(negedge clock); hold_rsp = 0; end
         send_noise(40);
      join
      drain();
   endtask

   initial begin
      req.valid = 1'b0;
      req.payload = '0;
      parser_reset();
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      drain();
      test_backpressure();
      while (n_sent < 1500) test_random_responses();
      send_idle = 0;
      recv_idle = 0;
      while (n_sent < 1850) test_random_responses();
      drain();
      if (errors == 0 && expected_rsps.size() == 0)
         $display("tb_http_response_body_deframer_unit: done, clean");
      else begin
         foreach (expected_rsps[i])
            $display("%0t: missing result, expected %p, actual none", $time, expected_rsps[i]);
         $display("tb_http_response_body_deframer_unit: done, errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_http_response_body_deframer_unit: done, errors");
      $finish;
   end
endmodule

// File: files.f
design/hrbd_pkg.sv
design/hrbd_if.sv
design/hrbd_front.sv
design/hrbd_queue.sv
design/http_response_body_deframer_unit.sv
bench/tb_http_response_body_deframer_unit.sv
